// ===== hw/rtl/distinct_permutation_generator_assert.svh =====
// Assertion macros shared by the distinct permutation generator modules.
`ifndef DISTINCT_PERMUTATION_GENERATOR_ASSERT_SVH
`define DISTINCT_PERMUTATION_GENERATOR_ASSERT_SVH

// Same-cycle implication, checked on every rising edge outside reset.
`define DPG_ASSERT_IMPL(name, ante, cons, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked on every rising edge outside reset.
`define DPG_ASSERT_NEXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hw/rtl/dpg_pkg.sv =====
// Types, constants and helper functions of the distinct permutation generator.
`timescale 1ns / 1ps
package dpg_pkg;

  localparam int LetterW  = 8;
  localparam int CountW   = 16;
  localparam int WordW    = 64;
  localparam int LenPortW = 4;

  // Inverses of the odd divisors modulo 2^16, for exact division.
  localparam logic [CountW-1:0] Inv3 = 16'd43691;
  localparam logic [CountW-1:0] Inv5 = 16'd52429;
  localparam logic [CountW-1:0] Inv7 = 16'd28087;

  typedef enum logic {
    ACT_LOAD = 1'b0,
    ACT_NEXT = 1'b1
  } action_e;

  typedef enum logic {
    KIND_COUNT = 1'b0,
    KIND_PERM  = 1'b1
  } kind_e;

  typedef enum logic [1:0] {
    STAT_OK        = 2'd0,
    STAT_OVERFLOW  = 2'd1,
    STAT_NONE_LEFT = 2'd2
  } status_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SORT_LOAD,
    ST_SORT_STEP,
    ST_CNT_MUL,
    ST_CNT_DIV,
    ST_PIV_LOAD,
    ST_PIV_SCAN,
    ST_SUCC_SCAN,
    ST_REV_LOAD,
    ST_REV_SWAP,
    ST_HS_LOAD,
    ST_HS_SCAN,
    ST_EMIT
  } state_e;

  typedef struct packed {
    logic [LetterW-1:0] cmp_a;
    logic [LetterW-1:0] cmp_b;
    logic [CountW-1:0]  mul_a;
    logic [CountW-1:0]  mul_b;
  } alu_req_t;

  typedef struct packed {
    logic              lt;
    logic              eq;
    logic [CountW-1:0] prod;
  } alu_rsp_t;

  typedef struct packed {
    logic                valid;
    kind_e               kind;
    logic [CountW-1:0]   count;
    logic [WordW-1:0]    word;
    logic [LenPortW-1:0] length;
    logic                fin;
    status_e             status;
  } res_t;

  // Right shift that removes the power-of-two part of a run length.
  function automatic logic [1:0] div_shift(input logic [3:0] k);
    logic [1:0] s;
    case (k)
      4'd2, 4'd6: s = 2'd1;
      4'd4:       s = 2'd2;
      4'd8:       s = 2'd3;
      default:    s = 2'd0;
    endcase
    return s;
  endfunction

  // Modular inverse of the odd part of a run length.
  function automatic logic [CountW-1:0] div_inv(input logic [3:0] k);
    logic [CountW-1:0] v;
    case (k)
      4'd3, 4'd6: v = Inv3;
      4'd5:       v = Inv5;
      4'd7:       v = Inv7;
      default:    v = 16'd1;
    endcase
    return v;
  endfunction

endpackage

// ===== hw/rtl/distinct_permutation_generator.sv =====
// Distinct permutation generator top level with its result register.
`timescale 1ns / 1ps
// A load without the last letter gives no reply; the last letter of a word gives
//   its count reply after the sort and count steps.
// A 'next' scans, swaps and checks the letter file one entry per cycle, using the
//   shared byte comparator for the scans; a refused 'next' goes straight to its reply.
// One transaction is worked on at a time; the result register frees the input side.
// Reset clears all control state and leaves no word loaded; the letter file is not cleared.
`include "distinct_permutation_generator_assert.svh"
module distinct_permutation_generator import dpg_pkg::*; #(
  parameter int MAX_LEN = 8
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  logic                action_i,
  input  logic [LetterW-1:0]  letter_i,
  input  logic                last_letter_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output logic                kind_o,
  output logic [CountW-1:0]   distinct_count_o,
  output logic [WordW-1:0]    word_o,
  output logic [LenPortW-1:0] word_length_o,
  output logic                final_one_o,
  output logic [1:0]          status_o
);

  localparam int LenW = $clog2(MAX_LEN + 1);
  localparam int IdxW = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;

  // Sequencer to letter file.
  logic [IdxW-1:0]    rd_addr;
  logic [LetterW-1:0] rd_data;
  logic               wa_en;
  logic [IdxW-1:0]    wa_addr;
  logic [LetterW-1:0] wa_data;
  logic               wb_en;
  logic [IdxW-1:0]    wb_addr;
  logic [LetterW-1:0] wb_data;
  logic [LenW-1:0]    cur_len;
  logic [WordW-1:0]   packed_word;

  // Sequencer to the shared comparator and multiplier.
  alu_req_t alu_req;
  alu_rsp_t alu_rsp;

  // Finished result from the sequencer.
  res_t res;

  // Output register. A new result may be loaded when the register is empty or its
  // current transaction completes in the same cycle.
  logic                out_valid_q;
  logic                out_free;
  kind_e               kind_q;
  logic [CountW-1:0]   count_q;
  logic [WordW-1:0]    word_q;
  logic [LenPortW-1:0] length_q;
  logic                fin_q;
  status_e             status_q;

  assign out_free = !out_valid_q || !out_stall_i;

  dpg_ctrl #(
    .MaxLen (MAX_LEN)
  ) u_ctrl (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .action_i      (action_i),
    .letter_i      (letter_i),
    .last_letter_i (last_letter_i),
    .out_free_i    (out_free),
    .res_o         (res),
    .rd_addr_o     (rd_addr),
    .rd_data_i     (rd_data),
    .wa_en_o       (wa_en),
    .wa_addr_o     (wa_addr),
    .wa_data_o     (wa_data),
    .wb_en_o       (wb_en),
    .wb_addr_o     (wb_addr),
    .wb_data_o     (wb_data),
    .len_o         (cur_len),
    .word_i        (packed_word),
    .alu_req_o     (alu_req),
    .alu_rsp_i     (alu_rsp)
  );

  dpg_store #(
    .MaxLen (MAX_LEN)
  ) u_store (
    .clk_i     (clk_i),
    .rd_addr_i (rd_addr),
    .rd_data_o (rd_data),
    .wa_en_i   (wa_en),
    .wa_addr_i (wa_addr),
    .wa_data_i (wa_data),
    .wb_en_i   (wb_en),
    .wb_addr_i (wb_addr),
    .wb_data_i (wb_data),
    .len_i     (cur_len),
    .word_o    (packed_word)
  );

  dpg_alu u_alu (
    .req_i (alu_req),
    .rsp_o (alu_rsp)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (res.valid) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res.valid) begin
      kind_q   <= res.kind;
      count_q  <= res.count;
      word_q   <= res.word;
      length_q <= res.length;
      fin_q    <= res.fin;
      status_q <= res.status;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign kind_o           = kind_q;
  assign distinct_count_o = count_q;
  assign word_o           = word_q;
  assign word_length_o    = length_q;
  assign final_one_o      = fin_q;
  assign status_o         = status_q;

  `DPG_ASSERT_NEXT(a_result_registered, res.valid, out_valid_q, "issued result did not reach the output register")
  `DPG_ASSERT_IMPL(a_no_overwrite, out_valid_q && out_stall_i, !res.valid, "waiting result overwritten by a new one")
  `DPG_ASSERT_IMPL(a_busy_while_issuing, res.valid, in_stall_o, "result issued while accepting a new transaction")
  `DPG_ASSERT_NEXT(a_taken_clears, out_valid_q && !out_stall_i && !res.valid, !out_valid_q, "delivered result shown twice")

endmodule

// ===== hw/rtl/dpg_alu.sv =====
// Shared byte comparator and 16-bit multiplier of the permutation generator.
`timescale 1ns / 1ps
module dpg_alu import dpg_pkg::*; (
  input  alu_req_t req_i,
  output alu_rsp_t rsp_o
);

  assign rsp_o.lt   = req_i.cmp_a < req_i.cmp_b;
  assign rsp_o.eq   = req_i.cmp_a == req_i.cmp_b;
  // Only the low half is kept: count products fit in 16 bits and exact divisions work modulo 2^16.
  assign rsp_o.prod = CountW'(req_i.mul_a * req_i.mul_b);

endmodule

// ===== hw/rtl/dpg_store.sv =====
// Letter register file with one read port, two write ports and a packed view.
`timescale 1ns / 1ps
module dpg_store import dpg_pkg::*; #(
  parameter int MaxLen = 8
) (
  input  logic                              clk_i,
  input  logic [((MaxLen > 1) ? $clog2(MaxLen) : 1)-1:0] rd_addr_i,
  output logic [LetterW-1:0]                rd_data_o,
  input  logic                              wa_en_i,
  input  logic [((MaxLen > 1) ? $clog2(MaxLen) : 1)-1:0] wa_addr_i,
  input  logic [LetterW-1:0]                wa_data_i,
  input  logic                              wb_en_i,
  input  logic [((MaxLen > 1) ? $clog2(MaxLen) : 1)-1:0] wb_addr_i,
  input  logic [LetterW-1:0]                wb_data_i,
  input  logic [$clog2(MaxLen + 1)-1:0]     len_i,
  output logic [WordW-1:0]                  word_o
);

  logic [LetterW-1:0] letters_q [MaxLen];

  always_ff @(posedge clk_i) begin
    if (wa_en_i) begin
      letters_q[wa_addr_i] <= wa_data_i;
    end
    if (wb_en_i) begin
      letters_q[wb_addr_i] <= wb_data_i;
    end
  end

  assign rd_data_o = (int'(rd_addr_i) < MaxLen) ? letters_q[rd_addr_i] : '0;

  // First letter lands in the top byte; places beyond the length read as zero.
  always_comb begin
    word_o = '0;
    for (int i = 0; i < MaxLen; i++) begin
      if (i < int'(len_i)) begin
        word_o[WordW-1-LetterW*i -: LetterW] = letters_q[i];
      end
    end
  end

endmodule

// ===== hw/rtl/dpg_ctrl.sv =====
// Sequencer of the permutation generator: load, sort, count and next-permutation.
`timescale 1ns / 1ps
`include "distinct_permutation_generator_assert.svh"
module dpg_ctrl import dpg_pkg::*; #(
  parameter int MaxLen = 8
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_stall_o,
  input  logic                              action_i,
  input  logic [LetterW-1:0]                letter_i,
  input  logic                              last_letter_i,
  input  logic                              out_free_i,
  output res_t                              res_o,
  output logic [((MaxLen > 1) ? $clog2(MaxLen) : 1)-1:0] rd_addr_o,
  input  logic [LetterW-1:0]                rd_data_i,
  output logic                              wa_en_o,
  output logic [((MaxLen > 1) ? $clog2(MaxLen) : 1)-1:0] wa_addr_o,
  output logic [LetterW-1:0]                wa_data_o,
  output logic                              wb_en_o,
  output logic [((MaxLen > 1) ? $clog2(MaxLen) : 1)-1:0] wb_addr_o,
  output logic [LetterW-1:0]                wb_data_o,
  output logic [$clog2(MaxLen + 1)-1:0]     len_o,
  input  logic [WordW-1:0]                  word_i,
  output alu_req_t                          alu_req_o,
  input  alu_rsp_t                          alu_rsp_i
);

  localparam int LenW = $clog2(MaxLen + 1);
  localparam int IdxW = (MaxLen > 1) ? $clog2(MaxLen) : 1;

  state_e             state_q, state_d;
  logic [LenW-1:0]    length_q, length_d;
  logic               started_q, started_d;
  logic               exhausted_q, exhausted_d;
  logic               overflowed_q, overflowed_d;
  logic               filling_q, filling_d;
  logic [CountW-1:0]  count_q, count_d;
  logic [LetterW-1:0] hold_q, hold_d;
  logic [LetterW-1:0] pv_q, pv_d;
  logic [LenW-1:0]    idx_q, idx_d;
  logic [LenW-1:0]    jdx_q, jdx_d;
  logic [LenW-1:0]    p_q, p_d;
  logic [LenW-1:0]    lo_q, lo_d;
  logic [LenW-1:0]    hi_q, hi_d;
  logic [LenW-1:0]    pass_q, pass_d;
  logic [LenW-1:0]    run_q, run_d;
  logic [CountW-1:0]  acc_q, acc_d;
  logic [CountW-1:0]  prod_q, prod_d;
  kind_e              rkind_q, rkind_d;
  status_e            rstat_q, rstat_d;
  logic               rfin_q, rfin_d;
  logic               rword_q, rword_d;

  logic [LenW-1:0] len_m1, idx_m1, idx_p1, jdx_m1, jdx_p1;

  assign len_m1 = length_q - LenW'(1);
  assign idx_m1 = idx_q - LenW'(1);
  assign idx_p1 = idx_q + LenW'(1);
  assign jdx_m1 = jdx_q - LenW'(1);
  assign jdx_p1 = jdx_q + LenW'(1);

  assign in_stall_o = (state_q != ST_IDLE);
  assign len_o      = length_q;

  always_comb begin
    res_o.valid  = (state_q == ST_EMIT) && out_free_i;
    res_o.kind   = rkind_q;
    res_o.count  = count_q;
    res_o.word   = rword_q ? word_i : '0;
    res_o.length = LenPortW'(length_q);
    res_o.fin    = rfin_q;
    res_o.status = rstat_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      length_q     <= '0;
      started_q    <= 1'b0;
      exhausted_q  <= 1'b1;
      overflowed_q <= 1'b0;
      filling_q    <= 1'b0;
      count_q      <= '0;
      hold_q       <= '0;
      pv_q         <= '0;
      idx_q        <= '0;
      jdx_q        <= '0;
      p_q          <= '0;
      lo_q         <= '0;
      hi_q         <= '0;
      pass_q       <= '0;
      run_q        <= '0;
      acc_q        <= '0;
      prod_q       <= '0;
      rkind_q      <= KIND_COUNT;
      rstat_q      <= STAT_OK;
      rfin_q       <= 1'b0;
      rword_q      <= 1'b0;
    end else begin
      state_q      <= state_d;
      length_q     <= length_d;
      started_q    <= started_d;
      exhausted_q  <= exhausted_d;
      overflowed_q <= overflowed_d;
      filling_q    <= filling_d;
      count_q      <= count_d;
      hold_q       <= hold_d;
      pv_q         <= pv_d;
      idx_q        <= idx_d;
      jdx_q        <= jdx_d;
      p_q          <= p_d;
      lo_q         <= lo_d;
      hi_q         <= hi_d;
      pass_q       <= pass_d;
      run_q        <= run_d;
      acc_q        <= acc_d;
      prod_q       <= prod_d;
      rkind_q      <= rkind_d;
      rstat_q      <= rstat_d;
      rfin_q       <= rfin_d;
      rword_q      <= rword_d;
    end
  end

  always_comb begin
    logic [LenW-1:0]    base;
    logic [LenW-1:0]    new_len;
    logic               new_ovf;
    logic [LetterW-1:0] big;
    logic [LetterW-1:0] little;

    base    = filling_q ? length_q : '0;
    new_len = base;
    new_ovf = filling_q & overflowed_q;
    big     = hold_q;
    little  = rd_data_i;

    state_d      = state_q;
    length_d     = length_q;
    started_d    = started_q;
    exhausted_d  = exhausted_q;
    overflowed_d = overflowed_q;
    filling_d    = filling_q;
    count_d      = count_q;
    hold_d       = hold_q;
    pv_d         = pv_q;
    idx_d        = idx_q;
    jdx_d        = jdx_q;
    p_d          = p_q;
    lo_d         = lo_q;
    hi_d         = hi_q;
    pass_d       = pass_q;
    run_d        = run_q;
    acc_d        = acc_q;
    prod_d       = prod_q;
    rkind_d      = rkind_q;
    rstat_d      = rstat_q;
    rfin_d       = rfin_q;
    rword_d      = rword_q;

    rd_addr_o = '0;
    wa_en_o   = 1'b0;
    wa_addr_o = '0;
    wa_data_o = '0;
    wb_en_o   = 1'b0;
    wb_addr_o = '0;
    wb_data_o = '0;
    alu_req_o = '0;

    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          if (action_e'(action_i) == ACT_LOAD) begin
            if (!filling_q) begin
              count_d     = '0;
              started_d   = 1'b0;
              exhausted_d = 1'b1;
              filling_d   = 1'b1;
            end
            if (int'(base) < MaxLen) begin
              wa_en_o   = 1'b1;
              wa_addr_o = base[IdxW-1:0];
              wa_data_o = letter_i;
              new_len   = base + LenW'(1);
            end else begin
              new_ovf = 1'b1;
            end
            length_d     = new_len;
            overflowed_d = new_ovf;
            if (last_letter_i) begin
              filling_d   = 1'b0;
              started_d   = 1'b0;
              exhausted_d = 1'b0;
              rkind_d     = KIND_COUNT;
              rstat_d     = new_ovf ? STAT_OVERFLOW : STAT_OK;
              rfin_d      = 1'b0;
              rword_d     = 1'b0;
              pass_d      = new_len - LenW'(1);
              acc_d       = 16'd1;
              idx_d       = '0;
              state_d     = (new_len > LenW'(1)) ? ST_SORT_LOAD : ST_CNT_MUL;
            end
          end else begin
            rkind_d = KIND_PERM;
            rfin_d  = 1'b0;
            if (filling_q || exhausted_q || (length_q == '0)) begin
              rstat_d = STAT_NONE_LEFT;
              rword_d = 1'b0;
              state_d = ST_EMIT;
            end else begin
              rstat_d = STAT_OK;
              rword_d = 1'b1;
              if (!started_q) begin
                started_d = 1'b1;
                state_d   = ST_HS_LOAD;
              end else begin
                state_d = ST_PIV_LOAD;
              end
            end
          end
        end
      end

      ST_SORT_LOAD: begin
        rd_addr_o = '0;
        hold_d    = rd_data_i;
        jdx_d     = LenW'(1);
        state_d   = ST_SORT_STEP;
      end

      ST_SORT_STEP: begin
        rd_addr_o       = jdx_q[IdxW-1:0];
        alu_req_o.cmp_a = rd_data_i;
        alu_req_o.cmp_b = hold_q;
        if (alu_rsp_i.lt) begin
          big    = hold_q;
          little = rd_data_i;
        end else begin
          big    = rd_data_i;
          little = hold_q;
        end
        wa_en_o   = 1'b1;
        wa_addr_o = jdx_m1[IdxW-1:0];
        wa_data_o = little;
        hold_d    = big;
        if (jdx_q == len_m1) begin
          wb_en_o   = 1'b1;
          wb_addr_o = jdx_q[IdxW-1:0];
          wb_data_o = big;
          pass_d    = pass_q - LenW'(1);
          if (pass_q == LenW'(1)) begin
            acc_d   = 16'd1;
            idx_d   = '0;
            state_d = ST_CNT_MUL;
          end else begin
            state_d = ST_SORT_LOAD;
          end
        end else begin
          jdx_d = jdx_p1;
        end
      end

      ST_CNT_MUL: begin
        rd_addr_o       = idx_q[IdxW-1:0];
        alu_req_o.cmp_a = rd_data_i;
        alu_req_o.cmp_b = hold_q;
        alu_req_o.mul_a = acc_q;
        alu_req_o.mul_b = CountW'(idx_q) + 16'd1;
        run_d   = ((idx_q != '0) && alu_rsp_i.eq) ? run_q + LenW'(1) : LenW'(1);
        hold_d  = rd_data_i;
        prod_d  = alu_rsp_i.prod;
        state_d = ST_CNT_DIV;
      end

      ST_CNT_DIV: begin
        alu_req_o.mul_a = prod_q >> div_shift(4'(run_q));
        alu_req_o.mul_b = div_inv(4'(run_q));
        acc_d = alu_rsp_i.prod;
        idx_d = idx_p1;
        if (idx_p1 == length_q) begin
          count_d = alu_rsp_i.prod;
          state_d = ST_EMIT;
        end else begin
          state_d = ST_CNT_MUL;
        end
      end

      ST_PIV_LOAD: begin
        rd_addr_o = len_m1[IdxW-1:0];
        hold_d    = rd_data_i;
        idx_d     = len_m1;
        state_d   = ST_PIV_SCAN;
      end

      ST_PIV_SCAN: begin
        rd_addr_o       = idx_m1[IdxW-1:0];
        alu_req_o.cmp_a = rd_data_i;
        alu_req_o.cmp_b = hold_q;
        if (alu_rsp_i.lt) begin
          p_d     = idx_m1;
          pv_d    = rd_data_i;
          jdx_d   = len_m1;
          state_d = ST_SUCC_SCAN;
        end else begin
          hold_d = rd_data_i;
          idx_d  = idx_m1;
          if (idx_m1 == '0) begin
            state_d = ST_HS_LOAD;
          end
        end
      end

      ST_SUCC_SCAN: begin
        rd_addr_o       = jdx_q[IdxW-1:0];
        alu_req_o.cmp_a = pv_q;
        alu_req_o.cmp_b = rd_data_i;
        if (alu_rsp_i.lt) begin
          wa_en_o   = 1'b1;
          wa_addr_o = p_q[IdxW-1:0];
          wa_data_o = rd_data_i;
          wb_en_o   = 1'b1;
          wb_addr_o = jdx_q[IdxW-1:0];
          wb_data_o = pv_q;
          lo_d      = p_q + LenW'(1);
          hi_d      = len_m1;
          state_d   = ST_REV_LOAD;
        end else begin
          jdx_d = jdx_m1;
        end
      end

      ST_REV_LOAD: begin
        if (lo_q < hi_q) begin
          rd_addr_o = lo_q[IdxW-1:0];
          hold_d    = rd_data_i;
          state_d   = ST_REV_SWAP;
        end else begin
          state_d = ST_HS_LOAD;
        end
      end

      ST_REV_SWAP: begin
        rd_addr_o = hi_q[IdxW-1:0];
        wa_en_o   = 1'b1;
        wa_addr_o = lo_q[IdxW-1:0];
        wa_data_o = rd_data_i;
        wb_en_o   = 1'b1;
        wb_addr_o = hi_q[IdxW-1:0];
        wb_data_o = hold_q;
        lo_d      = lo_q + LenW'(1);
        hi_d      = hi_q - LenW'(1);
        state_d   = ST_REV_LOAD;
      end

      ST_HS_LOAD: begin
        rd_addr_o = '0;
        hold_d    = rd_data_i;
        idx_d     = LenW'(1);
        state_d   = ST_HS_SCAN;
      end

      ST_HS_SCAN: begin
        if (idx_q == length_q) begin
          rfin_d      = 1'b1;
          exhausted_d = 1'b1;
          state_d     = ST_EMIT;
        end else begin
          rd_addr_o       = idx_q[IdxW-1:0];
          alu_req_o.cmp_a = hold_q;
          alu_req_o.cmp_b = rd_data_i;
          if (alu_rsp_i.lt) begin
            rfin_d  = 1'b0;
            state_d = ST_EMIT;
          end else begin
            hold_d = rd_data_i;
            idx_d  = idx_p1;
          end
        end
      end

      ST_EMIT: begin
        if (out_free_i) begin
          state_d = ST_IDLE;
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  `DPG_ASSERT_IMPL(a_sort_needs_two, (state_q == ST_SORT_LOAD) || (state_q == ST_SORT_STEP), length_q > LenW'(1), "sort running on a word shorter than two letters")
  `DPG_ASSERT_IMPL(a_pivot_in_range, state_q == ST_PIV_SCAN, (idx_q != '0) && (idx_q < length_q), "pivot scan index out of range")
  `DPG_ASSERT_IMPL(a_rev_ordered, state_q == ST_REV_SWAP, (lo_q < hi_q) && (hi_q < length_q), "suffix reversal bounds crossed")
  `DPG_ASSERT_NEXT(a_count_clears_exhausted, res_o.valid && (res_o.kind == KIND_COUNT), !exhausted_q && !filling_q, "count reply left the word unavailable")

endmodule

// ===== verif/distinct_permutation_checker.sv =====
// Self-checking monitor that predicts and compares the permutation generator's replies.
`timescale 1ns / 1ps
module distinct_permutation_checker import dpg_pkg::*; #(
  parameter int MAX_LEN = 8
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  input  logic                in_stall_i,
  input  logic                action_i,
  input  logic [LetterW-1:0]  letter_i,
  input  logic                last_letter_i,
  input  logic                out_valid_i,
  input  logic                out_stall_i,
  input  logic                kind_i,
  input  logic [CountW-1:0]   distinct_count_i,
  input  logic [WordW-1:0]    word_i,
  input  logic [LenPortW-1:0] word_length_i,
  input  logic                final_one_i,
  input  logic [1:0]          status_i,
  output int unsigned         mismatches_o,
  output int unsigned         replies_waiting_o,
  output int unsigned         replies_seen_o,
  output int unsigned         finals_seen_o,
  output int unsigned         refusals_seen_o
);

  typedef struct {
    kind_e               kind;
    logic [CountW-1:0]   count;
    logic [WordW-1:0]    word;
    logic [LenPortW-1:0] length;
    logic                fin;
    status_e             status;
  } reply_t;

  reply_t expected_replies[$];

  // Shadow copy of the word store and its flags.
  logic [LetterW-1:0]  word_letters [MAX_LEN];
  logic [LenPortW-1:0] kept_len;
  logic [CountW-1:0]   perm_count;
  bit first_given, list_done, dropped_any, loading;

  int unsigned mismatches, replies_seen, finals_seen, refusals_seen;

  function automatic int unsigned factorial(input int k);
    int unsigned f;
    int m;
    f = 1;
    for (m = 2; m <= k; m++) f *= m;
    return f;
  endfunction

  task automatic predict_reply(input action_e act, input logic [LetterW-1:0] b,
                               input logic last);
    reply_t r;
    logic [LetterW-1:0] t;
    int i, j, p, lo, hi, run;
    int unsigned denom;
    bit fin;
    if (act == ACT_LOAD) begin
      if (!loading) begin
        kept_len = '0;
        dropped_any = 1'b0;
        perm_count = '0;
        first_given = 1'b0;
        list_done = 1'b1;
        loading = 1'b1;
      end
      if (kept_len < MAX_LEN) begin
        word_letters[kept_len] = b;
        kept_len++;
      end else begin
        dropped_any = 1'b1;
      end
      if (!last) return;
      loading = 1'b0;
      // Insertion sort into ascending byte order.
      for (i = 1; i < kept_len; i++) begin
        t = word_letters[i];
        j = i;
        while (j > 0 && word_letters[j-1] > t) begin
          word_letters[j] = word_letters[j-1];
          j--;
        end
        word_letters[j] = t;
      end
      // Multinomial: n! over the factorial of every run of equal letters.
      denom = 1;
      i = 0;
      while (i < kept_len) begin
        run = 1;
        while (i + run < kept_len && word_letters[i+run] == word_letters[i]) run++;
        denom *= factorial(run);
        i += run;
      end
      perm_count = CountW'(factorial(kept_len) / denom);
      first_given = 1'b0;
      list_done = 1'b0;
      r.kind = KIND_COUNT;
      r.count = perm_count;
      r.word = '0;
      r.length = kept_len;
      r.fin = 1'b0;
      r.status = dropped_any ? STAT_OVERFLOW : STAT_OK;
      expected_replies.push_back(r);
      return;
    end
    r.kind = KIND_PERM;
    r.count = perm_count;
    r.length = kept_len;
    r.word = '0;
    r.fin = 1'b0;
    r.status = STAT_NONE_LEFT;
    if (!(loading || list_done || kept_len == 0)) begin
      if (!first_given) begin
        first_given = 1'b1;
      end else begin
        // Classic next-permutation: find the pivot, swap with its successor, reverse tail.
        i = kept_len - 1;
        while (i > 0 && word_letters[i-1] >= word_letters[i]) i--;
        if (i > 0) begin
          p = i - 1;
          j = kept_len - 1;
          while (word_letters[j] <= word_letters[p]) j--;
          t = word_letters[p];
          word_letters[p] = word_letters[j];
          word_letters[j] = t;
          lo = i;
          hi = kept_len - 1;
          while (lo < hi) begin
            t = word_letters[lo];
            word_letters[lo] = word_letters[hi];
            word_letters[hi] = t;
            lo++;
            hi--;
          end
        end
      end
      fin = 1'b1;
      for (i = 0; i + 1 < kept_len; i++)
        if (word_letters[i] < word_letters[i+1]) fin = 1'b0;
      if (fin) list_done = 1'b1;
      for (i = 0; i < kept_len; i++) r.word[8*(7-i) +: 8] = word_letters[i];
      r.fin = fin;
      r.status = STAT_OK;
    end
    expected_replies.push_back(r);
  endtask

  task automatic check_field(input string name, input longint unsigned want,
                             input longint unsigned got);
    if (want != got) begin
      $display("%0t: %s differs, expected 0x%0h, actual 0x%0h", $time, name, want, got);
      mismatches++;
    end
  endtask

  always @(posedge clk_i) begin
    reply_t r;
    int k;
    if (!rst_ni) begin
      for (k = 0; k < MAX_LEN; k++) word_letters[k] = '0;
      kept_len = '0;
      perm_count = '0;
      first_given = 1'b0;
      list_done = 1'b1;
      dropped_any = 1'b0;
      loading = 1'b0;
      expected_replies.delete();
      mismatches = 0;
      replies_seen = 0;
      finals_seen = 0;
      refusals_seen = 0;
    end else begin
      // Outputs first: a reply can never stem from the input taken at the same edge.
      if (out_valid_i && !out_stall_i) begin
        replies_seen++;
        if (final_one_i) finals_seen++;
        if (kind_i == KIND_PERM && status_i == STAT_NONE_LEFT) refusals_seen++;
        if (expected_replies.size() == 0) begin
          $display("%0t: reply with nothing expected, expected none, actual kind %0d word 0x%0h",
                   $time, kind_i, word_i);
          mismatches++;
        end else begin
          r = expected_replies.pop_front();
          check_field("kind", r.kind, kind_i);
          check_field("distinct_count", r.count, distinct_count_i);
          check_field("word", r.word, word_i);
          check_field("word_length", r.length, word_length_i);
          check_field("final_one", r.fin, final_one_i);
          check_field("status", r.status, status_i);
        end
      end
      if (in_valid_i && !in_stall_i)
        predict_reply(action_e'(action_i), letter_i, last_letter_i);
    end
    mismatches_o      <= mismatches;
    replies_waiting_o <= expected_replies.size();
    replies_seen_o    <= replies_seen;
    finals_seen_o     <= finals_seen;
    refusals_seen_o   <= refusals_seen;
  end

endmodule

// ===== verif/tb_distinct_permutation_generator.sv =====
// Top-level testbench of the distinct permutation generator: stimulus, back-pressure and verdict.
`timescale 1ns / 1ps
module tb_distinct_permutation_generator;
  import dpg_pkg::*;

  // Roughly one cycle in five is an idle on either side.
  localparam int IdlePct     = 19;
  localparam int ItemTarget  = 700;
  // Even the slowest reply (eight letters) comes well within this limit, so a stretch
  // that long without any handshake can only mean a hang.
  localparam int QuietLimit  = 4000;
  localparam int DrainCycles = 120;

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                in_valid_i = 1'b0;
  logic                in_stall_o;
  logic                action_i = ACT_LOAD;
  logic [LetterW-1:0]  letter_i = '0;
  logic                last_letter_i = 1'b0;
  logic                out_valid_o;
  logic                out_stall_i = 1'b0;
  logic                kind_o;
  logic [CountW-1:0]   distinct_count_o;
  logic [WordW-1:0]    word_o;
  logic [LenPortW-1:0] word_length_o;
  logic                final_one_o;
  logic [1:0]          status_o;

  int unsigned mismatches, replies_waiting, replies_seen, finals_seen, refusals_seen;
  int unsigned items_sent, words_loaded, quiet_cycles;
  // While set, neither side inserts idle cycles: the back-to-back stretch.
  bit calm = 1'b0;

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  distinct_permutation_generator uut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .in_stall_o       (in_stall_o),
    .action_i         (action_i),
    .letter_i         (letter_i),
    .last_letter_i    (last_letter_i),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .kind_o           (kind_o),
    .distinct_count_o (distinct_count_o),
    .word_o           (word_o),
    .word_length_o    (word_length_o),
    .final_one_o      (final_one_o),
    .status_o         (status_o)
  );

  distinct_permutation_checker u_checker (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .in_valid_i        (in_valid_i),
    .in_stall_i        (in_stall_o),
    .action_i          (action_i),
    .letter_i          (letter_i),
    .last_letter_i     (last_letter_i),
    .out_valid_i       (out_valid_o),
    .out_stall_i       (out_stall_i),
    .kind_i            (kind_o),
    .distinct_count_i  (distinct_count_o),
    .word_i            (word_o),
    .word_length_i     (word_length_o),
    .final_one_i       (final_one_o),
    .status_i          (status_o),
    .mismatches_o      (mismatches),
    .replies_waiting_o (replies_waiting),
    .replies_seen_o    (replies_seen),
    .finals_seen_o     (finals_seen),
    .refusals_seen_o   (refusals_seen)
  );

  // The receiving side stalls at random, except during the calm stretch.
  always @(posedge clk_i) begin
    out_stall_i <= !calm && ($urandom_range(0, 99) < IdlePct);
  end

  // Watchdog: any handshake on either channel restarts the count of quiet cycles.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles >= QuietLimit) begin
        $display("%0t: no transaction for %0d cycles, %0d replies still awaited",
                 $time, quiet_cycles, replies_waiting);
        $display("SCOREBOARD MISMATCH");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end else begin
      quiet_cycles <= 0;
    end
  end

  // Presents one input transaction, possibly after a few idle cycles, and holds it
  // steady until the block takes it. Every signal is assigned once per time step.
  task automatic send_item(input action_e act, input logic [LetterW-1:0] b,
                           input logic last);
    while (!calm && $urandom_range(0, 99) < IdlePct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i    <= 1'b1;
    action_i      <= act;
    letter_i      <= b;
    last_letter_i <= last;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    items_sent++;
    if (act == ACT_LOAD && last) words_loaded++;
  endtask

  initial begin
    logic [LetterW-1:0] syms [3];
    int len, nsym, k, nexts, pick;
    bit wild;

    items_sent = 0;
    words_loaded = 0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed part. A 'next' before anything has been loaded must be refused.
    send_item(ACT_NEXT, 8'hFF, 1'b1);
    // One-letter word: a single permutation, marked final, then nothing left.
    send_item(ACT_LOAD, 8'h41, 1'b1);
    send_item(ACT_NEXT, 8'h00, 1'b0);
    send_item(ACT_NEXT, 8'hFF, 1'b1);
    // Repeated extreme bytes: three distinct arrangements, then a refusal.
    send_item(ACT_LOAD, 8'hFF, 1'b0);
    send_item(ACT_LOAD, 8'h00, 1'b0);
    send_item(ACT_LOAD, 8'hFF, 1'b1);
    repeat (4) send_item(ACT_NEXT, 8'h5A, 1'b0);
    // A 'next' in the middle of a load is refused and leaves the load going; the
    // word then runs two letters past capacity, so those are dropped and flagged.
    send_item(ACT_LOAD, 8'h80, 1'b0);
    send_item(ACT_NEXT, 8'hA5, 1'b0);
    send_item(ACT_LOAD, 8'h01, 1'b0);
    send_item(ACT_LOAD, 8'h7F, 1'b0);
    send_item(ACT_LOAD, 8'hFE, 1'b0);
    send_item(ACT_LOAD, 8'h80, 1'b0);
    send_item(ACT_LOAD, 8'h00, 1'b0);
    send_item(ACT_LOAD, 8'hFF, 1'b0);
    send_item(ACT_LOAD, 8'h55, 1'b0);
    send_item(ACT_LOAD, 8'hAA, 1'b0);
    send_item(ACT_LOAD, 8'h33, 1'b1);
    repeat (3) send_item(ACT_NEXT, 8'h00, 1'b1);

    // Random part: mostly complete words followed by a run of 'next' requests, so
    // that short words are walked to the end and past it. A small share is noise.
    while (items_sent < ItemTarget) begin
      calm = (items_sent >= 300 && items_sent < 420);
      pick = $urandom_range(0, 99);
      if (pick < 8) begin
        repeat ($urandom_range(1, 3))
          send_item(action_e'($urandom_range(0, 1)), LetterW'($urandom_range(0, 255)),
                    $urandom_range(0, 1));
      end else begin
        pick = $urandom_range(0, 99);
        if (pick < 70)      len = $urandom_range(1, 4);
        else if (pick < 90) len = $urandom_range(5, 6);
        else if (pick < 96) len = $urandom_range(7, 8);
        else                len = $urandom_range(9, 11);
        // A small alphabet gives repeated letters; a wild word uses any byte.
        wild = ($urandom_range(0, 3) == 0);
        nsym = $urandom_range(1, 3);
        for (k = 0; k < 3; k++) begin
          case ($urandom_range(0, 5))
            0:       syms[k] = 8'h00;
            1:       syms[k] = 8'hFF;
            default: syms[k] = LetterW'($urandom_range(0, 255));
          endcase
        end
        for (k = 0; k < len; k++) begin
          if ($urandom_range(0, 99) < 4)
            send_item(ACT_NEXT, LetterW'($urandom_range(0, 255)), $urandom_range(0, 1));
          send_item(ACT_LOAD,
                    wild ? LetterW'($urandom_range(0, 255)) : syms[$urandom_range(0, nsym - 1)],
                    k == len - 1);
        end
        nexts = (len <= 4) ? $urandom_range(0, 27) : $urandom_range(0, 22);
        repeat (nexts)
          send_item(ACT_NEXT, LetterW'($urandom_range(0, 255)), $urandom_range(0, 1));
      end
    end
    calm = 1'b0;
    in_valid_i <= 1'b0;

    // Let every awaited reply arrive (the watchdog bounds this), then give the block
    // time to show any stray reply before the verdict.
    while (replies_waiting != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);

    $display("Run covered %0d input transactions in %0d completed words and %0d replies,",
             items_sent, words_loaded, replies_seen);
    $display("of which %0d were final permutations and %0d refused 'next' requests.",
             finals_seen, refusals_seen);
    if (mismatches == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

// ===== files.f =====
+incdir+hw/rtl
hw/rtl/dpg_pkg.sv
hw/rtl/dpg_alu.sv
hw/rtl/dpg_store.sv
hw/rtl/dpg_ctrl.sv
hw/rtl/distinct_permutation_generator.sv
verif/distinct_permutation_checker.sv
verif/tb_distinct_permutation_generator.sv
